@@ sv/assert_macros.svh @@
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion shorthands, all clocked on clk and disabled during arst_n.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every clock edge out of reset
`define U2J_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// condition must never be seen at a clock edge out of reset
`define U2J_NEVER(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) else $error(msg);

`endif

@@ sv/u2j_pkg.sv @@
// ----------------------------------------------------------------------------
// u2j_pkg
// Shared types, constants and character helpers for the UTF-8 to JSON
// string escaper.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package u2j_pkg;

	// command queue geometry
	localparam int Q_DEPTH = 4;
	localparam int Q_AW    = $clog2(Q_DEPTH);
	localparam int Q_CW    = $clog2(Q_DEPTH + 1);

	// ASCII codes used by the escaper
	localparam logic [6:0] CH_QUOTE = 7'h22;
	localparam logic [6:0] CH_BSL   = 7'h5C;
	localparam logic [6:0] CH_U     = 7'h75;

	// how the body of one word is written out
	typedef enum logic [2:0] {
		K_NONE,   // no code point
		K_PLAIN,  // printable ASCII as is
		K_BSL,    // backslash then the character
		K_ESC,    // one \uXXXX escape
		K_PAIR    // surrogate pair, two escapes
	} kind_t;

	// one queued command: everything the back end needs for one input byte
	typedef struct packed {
		logic        has_open;
		logic        has_close;
		kind_t       kind;
		logic [15:0] v1;   // char, escape value or high surrogate
		logic [9:0]  v2;   // low 10 bits of the low surrogate
	} cmd_t;

	// queue status seen by the front end
	typedef struct packed {
		logic full;
		logic nonempty;
	} q_stat_t;

	// number of body characters for a kind
	function automatic logic [3:0] body_len(kind_t k);
		case (k)
			K_PLAIN: body_len = 4'd1;
			K_BSL:   body_len = 4'd2;
			K_ESC:   body_len = 4'd6;
			K_PAIR:  body_len = 4'd12;
			default: body_len = 4'd0;
		endcase
	endfunction

	// lowercase hex digit
	function automatic logic [6:0] hex_char(logic [3:0] v);
		if (v < 4'd10)
			hex_char = 7'h30 + {3'b000, v};
		else
			hex_char = 7'h57 + {3'b000, v};
	endfunction

	// total characters for a command, 1 to 14
	function automatic logic [3:0] cmd_len(cmd_t c);
		cmd_len = body_len(c.kind) + {3'b000, c.has_open} + {3'b000, c.has_close};
	endfunction

	// character at position pos of a command
	function automatic logic [6:0] cmd_char(cmd_t c, logic [3:0] pos);
		logic [3:0]  b;
		logic [3:0]  d;
		logic [15:0] w;
		b = pos - {3'b000, c.has_open};
		d = (b >= 4'd6) ? (b - 4'd6) : b;
		w = (b >= 4'd6) ? {6'b110111, c.v2} : c.v1;
		if (c.has_open && pos == 4'd0)
			cmd_char = CH_QUOTE;
		else if (b >= body_len(c.kind))
			cmd_char = CH_QUOTE;
		else begin
			case (c.kind)
				K_PLAIN: cmd_char = c.v1[6:0];
				K_BSL:   cmd_char = (b == 4'd0) ? CH_BSL : c.v1[6:0];
				K_ESC, K_PAIR: begin
					case (d)
						4'd0:    cmd_char = CH_BSL;
						4'd1:    cmd_char = CH_U;
						4'd2:    cmd_char = hex_char(w[15:12]);
						4'd3:    cmd_char = hex_char(w[11:8]);
						4'd4:    cmd_char = hex_char(w[7:4]);
						default: cmd_char = hex_char(w[3:0]);
					endcase
				end
				default: cmd_char = CH_QUOTE;
			endcase
		end
	endfunction

endpackage

@@ sv/u2j_in_if.sv @@
// ----------------------------------------------------------------------------
// u2j_in_if
// Byte input channel: valid/ready handshake with one UTF-8 byte and markers.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface u2j_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] in_byte;
	logic       string_start;
	logic       string_end;

	modport source (output valid, output in_byte, output string_start,
		output string_end, input ready);
	modport sink (input valid, input in_byte, input string_start,
		input string_end, output ready);
endinterface

@@ sv/u2j_out_if.sv @@
// ----------------------------------------------------------------------------
// u2j_out_if
// Character output channel: valid/ready handshake with one ASCII character.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface u2j_out_if;
	logic       valid;
	logic       ready;
	logic [6:0] out_char;
	logic       out_last;

	modport source (output valid, output out_char, output out_last, input ready);
	modport sink (input valid, input out_char, input out_last, output ready);
endinterface

@@ sv/u2j_front.sv @@
// ----------------------------------------------------------------------------
// u2j_front
// UTF-8 decoder: takes one byte a cycle while the queue has room, tracks the
// pending sequence and pushes one command word per byte that causes output.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module u2j_front (
	input  logic             clk,
	input  logic             arst_n,
	u2j_in_if.sink           in_ch,
	input  u2j_pkg::q_stat_t qs,
	output logic             push,
	output u2j_pkg::cmd_t    cmd
);
	import u2j_pkg::*;

	logic [1:0]  pend_q;
	logic [20:0] acc_q;

	logic        acc_in;
	logic [1:0]  pend_eff;
	logic [20:0] acc_eff;
	logic [1:0]  pend_nx;
	logic [20:0] acc_nx;
	logic        has_code;
	logic [20:0] code;
	logic [20:0] sup;
	logic [15:0] hi;

	assign in_ch.ready = !qs.full;
	assign acc_in      = in_ch.valid && in_ch.ready;

	// decode step
	always_comb begin
		pend_eff = in_ch.string_start ? 2'd0 : pend_q;
		acc_eff  = in_ch.string_start ? 21'd0 : acc_q;
		pend_nx  = 2'd0;
		acc_nx   = 21'd0;
		has_code = 1'b0;
		code     = {13'd0, in_ch.in_byte};
		if (pend_eff != 2'd0 && in_ch.in_byte[7:6] == 2'b10) begin
			// continuation byte
			code    = {acc_eff[14:0], in_ch.in_byte[5:0]};
			pend_nx = pend_eff - 2'd1;
			if (pend_nx == 2'd0)
				has_code = 1'b1;
			else
				acc_nx = code;
		end else if (!in_ch.in_byte[7]) begin
			has_code = 1'b1;
		end else if (in_ch.in_byte[7:5] == 3'b110) begin
			pend_nx = 2'd1;
			acc_nx  = {16'd0, in_ch.in_byte[4:0]};
		end else if (in_ch.in_byte[7:4] == 4'b1110) begin
			pend_nx = 2'd2;
			acc_nx  = {17'd0, in_ch.in_byte[3:0]};
		end else if (in_ch.in_byte[7:3] == 5'b11110) begin
			pend_nx = 2'd3;
			acc_nx  = {18'd0, in_ch.in_byte[2:0]};
		end
		if (in_ch.string_end) begin
			pend_nx = 2'd0;
			acc_nx  = 21'd0;
		end
	end

	// classify the finished code point
	assign sup = code - 21'h010000;
	assign hi  = {5'd0, sup[20:10]} + 16'hD800;

	always_comb begin
		cmd.has_open  = in_ch.string_start;
		cmd.has_close = in_ch.string_end;
		cmd.v1        = code[15:0];
		cmd.v2        = code[9:0];
		if (!has_code)
			cmd.kind = K_NONE;
		else if (code == 21'h22 || code == 21'h5C)
			cmd.kind = K_BSL;
		else if (code >= 21'h20 && code <= 21'h7E)
			cmd.kind = K_PLAIN;
		else if (code > 21'h00FFFF) begin
			cmd.kind = K_PAIR;
			cmd.v1   = hi;
		end else
			cmd.kind = K_ESC;
	end

	assign push = acc_in && (has_code || in_ch.string_start || in_ch.string_end);

	// decoder state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_q <= 2'd0;
			acc_q  <= 21'd0;
		end else if (acc_in) begin
			pend_q <= pend_nx;
			acc_q  <= acc_nx;
		end
	end

endmodule

@@ sv/u2j_queue.sv @@
// ----------------------------------------------------------------------------
// u2j_queue
// Small command FIFO between decoder and expander.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module u2j_queue (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  u2j_pkg::cmd_t    din,
	input  logic             pop,
	output u2j_pkg::cmd_t    dout,
	output u2j_pkg::q_stat_t qs
);
	import u2j_pkg::*;

	cmd_t            mem_q [Q_DEPTH];
	logic [Q_AW-1:0] wr_q;
	logic [Q_AW-1:0] rd_q;
	logic [Q_CW-1:0] cnt_q;

	assign dout        = mem_q[rd_q];
	assign qs.full     = (cnt_q == Q_CW'(Q_DEPTH));
	assign qs.nonempty = (cnt_q != '0);

	// entry storage
	always_ff @(posedge clk) begin
		if (push)
			mem_q[wr_q] <= din;
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push)
				wr_q <= wr_q + Q_AW'(1);
			if (pop)
				rd_q <= rd_q + Q_AW'(1);
			if (push && !pop)
				cnt_q <= cnt_q + Q_CW'(1);
			else if (pop && !push)
				cnt_q <= cnt_q - Q_CW'(1);
		end
	end

endmodule

@@ sv/u2j_back.sv @@
// ----------------------------------------------------------------------------
// u2j_back
// Expander: walks the head command one character a cycle into the output
// register, while that register is empty or being read.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module u2j_back (
	input  logic          clk,
	input  logic          arst_n,
	input  u2j_pkg::cmd_t cmd,
	input  logic          cmd_valid,
	output logic          pop,
	u2j_out_if.source     out_ch
);
	import u2j_pkg::*;

	logic [3:0] pos_q;
	logic       ov_q;
	logic [6:0] oc_q;
	logic       ol_q;

	logic       load;
	logic       last;

	assign load = cmd_valid && (!ov_q || out_ch.ready);
	assign last = (pos_q == cmd_len(cmd) - 4'd1);
	assign pop  = load && last;

	assign out_ch.valid    = ov_q;
	assign out_ch.out_char = oc_q;
	assign out_ch.out_last = ol_q;

	// position within the head command
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			pos_q <= 4'd0;
		else if (load)
			pos_q <= last ? 4'd0 : pos_q + 4'd1;
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			ov_q <= 1'b0;
		else if (load)
			ov_q <= 1'b1;
		else if (out_ch.ready)
			ov_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (load) begin
			oc_q <= cmd_char(cmd, pos_q);
			ol_q <= last;
		end
	end

endmodule

@@ sv/utf8_to_json_string_escaper_unit.sv @@
// ----------------------------------------------------------------------------
// utf8_to_json_string_escaper_unit
// UTF-8 byte stream in, escaped and quoted JSON string literal out.
// ----------------------------------------------------------------------------
// channel  dir  payload                            word
// in_ch    in   in_byte[7:0] string_start string_end  one UTF-8 byte
// out_ch   out  out_char[6:0] out_last              one ASCII character
//
// The decoder takes one byte per cycle while the 4-entry command queue has room.
// The expander emits one character per cycle while out_ch.ready allows, 0 to 13
// per byte, so the output side sets the sustained rate: one byte a cycle for
// plain ASCII. With the queue empty, an accepted byte is written to the queue,
// then its first character is loaded into the output register.
// Reset clears the decoder, queue pointers and output valid; no clearing pass.
// Output stalls fill the queue, which then drops in_ch.ready.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module utf8_to_json_string_escaper_unit (
	input  logic      clk,
	input  logic      arst_n,
	u2j_in_if.sink    in_ch,
	u2j_out_if.source out_ch
);
	import u2j_pkg::*;

	logic    q_push;
	cmd_t    q_din;
	logic    q_pop;
	cmd_t    q_dout;
	q_stat_t q_stat;

	// decoder
	u2j_front u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.in_ch  (in_ch),
		.qs     (q_stat),
		.push   (q_push),
		.cmd    (q_din)
	);

	// command queue
	u2j_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (q_push),
		.din    (q_din),
		.pop    (q_pop),
		.dout   (q_dout),
		.qs     (q_stat)
	);

	// expander
	u2j_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (q_dout),
		.cmd_valid (q_stat.nonempty),
		.pop       (q_pop),
		.out_ch    (out_ch)
	);

	// checks
	`U2J_NEVER(a_pop_empty, q_pop && !q_stat.nonempty, "pop from empty command queue")
	`U2J_NEVER(a_push_full, q_push && q_stat.full, "push into full command queue")
	`U2J_ASSERT(a_empty_cmd, q_push && q_din.kind == K_NONE |-> q_din.has_open || q_din.has_close, "command with no characters")
	`U2J_ASSERT(a_push_seen, q_push |=> q_stat.nonempty, "pushed command missing from queue")

endmodule

@@ bench/utf8_to_json_string_escaper_unit_test.sv @@
// ----------------------------------------------------------------------------
// utf8_to_json_string_escaper_unit_test
// Self-checking bench for the UTF-8 to JSON string escaper. A driver pushes
// byte words from a stimulus queue and a predictor decodes each accepted
// byte into the characters the block should emit. A monitor compares every
// character word and its last flag with the oldest prediction. Both sides
// idle at random. One long output hold fills the block, and two sender
// pauses drain it completely.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module utf8_to_json_string_escaper_unit_test;

	import u2j_pkg::*;

	localparam int RANDOM_BYTES = 500;
	localparam int TAIL_CYCLES  = 20;
	localparam int IDLE_LIMIT   = 1000;
	localparam int HOLD_AT      = 300;
	localparam int HOLD_LEN     = 150;
	localparam int MAX_PRINTS   = 40;

	// code point ranges used by the escaping rules
	localparam logic [20:0] PRINT_LO  = 21'h000020;
	localparam logic [20:0] PRINT_HI  = 21'h00007E;
	localparam logic [20:0] BMP_TOP   = 21'h00FFFF;
	localparam logic [20:0] PLANE1    = 21'h010000;
	localparam logic [15:0] HI_SURR   = 16'hD800;
	localparam logic [15:0] LO_SURR   = 16'hDC00;

	typedef struct {
		logic [7:0] data;
		logic       opens;
		logic       closes;
		logic       drain;   // wait for the output to empty before sending
	} byte_word_t;

	typedef struct {
		logic [6:0] ch;
		logic       last;
	} char_word_t;

	logic clk;
	logic arst_n;

	u2j_in_if  in_ch ();
	u2j_out_if out_ch ();

	utf8_to_json_string_escaper_unit dut (
		.clk    (clk),
		.arst_n (arst_n),
		.in_ch  (in_ch),
		.out_ch (out_ch)
	);

	byte_word_t  pending_bytes[$];
	char_word_t  expected_chars[$];
	logic [6:0]  burst[$];

	// decoder state of the predictor
	logic [1:0]  dec_pending;
	logic [20:0] dec_code;

	int unsigned errors;
	int unsigned bytes_sent;
	int unsigned strings_sent;
	int unsigned chars_seen;
	int unsigned pairs_seen;

	// ------------------------------------------------------------------
	// predictor
	// ------------------------------------------------------------------
	function automatic void add_char(input logic [6:0] c);
		burst = {burst, c};
	endfunction

	function automatic logic [6:0] nibble_ascii(input logic [3:0] v);
		return (v < 4'd10) ? 7'h30 + 7'(v) : 7'h61 + 7'(v) - 7'd10;
	endfunction

	function automatic void push_escape(input logic [15:0] v);
		add_char(CH_BSL);
		add_char(CH_U);
		add_char(nibble_ascii(v[15:12]));
		add_char(nibble_ascii(v[11:8]));
		add_char(nibble_ascii(v[7:4]));
		add_char(nibble_ascii(v[3:0]));
	endfunction

	function automatic void push_code(input logic [20:0] cp);
		logic [20:0] s;
		logic [20:0] hi;
		s = cp - PLANE1;
		hi = (s >> 10) + 21'(HI_SURR);
		if (cp == 21'(CH_QUOTE) || cp == 21'(CH_BSL)) begin
			add_char(CH_BSL);
			add_char(cp[6:0]);
		end else if (cp >= PRINT_LO && cp <= PRINT_HI) begin
			add_char(cp[6:0]);
		end else if (cp > BMP_TOP) begin
			push_escape(hi[15:0]);
			push_escape({6'd0, s[9:0]} + LO_SURR);
			pairs_seen++;
		end else begin
			push_escape(cp[15:0]);
		end
	endfunction

	// decode one accepted byte and queue the characters it should produce
	function automatic void escape_byte(input logic [7:0] b, input logic opens,
		input logic closes);
		char_word_t w;
		burst.delete();
		if (opens) begin
			dec_pending = 2'd0;
			dec_code = '0;
			add_char(CH_QUOTE);
		end
		if (dec_pending != 2'd0 && b[7:6] == 2'b10) begin
			dec_code = {dec_code[14:0], b[5:0]};
			dec_pending = dec_pending - 2'd1;
			if (dec_pending == 2'd0) begin
				push_code(dec_code);
				dec_code = '0;
			end
		end else begin
			// any non-continuation byte restarts the decoder
			dec_pending = 2'd0;
			dec_code = '0;
			if (!b[7])
				push_code({14'd0, b[6:0]});
			else if (b[7:5] == 3'b110) begin
				dec_pending = 2'd1;
				dec_code = {16'd0, b[4:0]};
			end else if (b[7:4] == 4'b1110) begin
				dec_pending = 2'd2;
				dec_code = {17'd0, b[3:0]};
			end else if (b[7:3] == 5'b11110) begin
				dec_pending = 2'd3;
				dec_code = {18'd0, b[2:0]};
			end
		end
		if (closes) begin
			dec_pending = 2'd0;
			dec_code = '0;
			add_char(CH_QUOTE);
		end
		for (int i = 0; i < burst.size(); i++) begin
			w.ch = burst[i];
			w.last = (i == burst.size() - 1);
			expected_chars = {expected_chars, w};
		end
	endfunction

	task automatic report_mismatch(input string msg);
		if (errors < MAX_PRINTS)
			$display("[%0t] mismatch: %s", $time, msg);
		errors++;
	endtask

	function automatic void queue_byte(input logic [7:0] b, input logic opens,
		input logic closes, input logic drain);
		byte_word_t w;
		w.data = b;
		w.opens = opens;
		w.closes = closes;
		w.drain = drain;
		pending_bytes = {pending_bytes, w};
	endfunction

	// ------------------------------------------------------------------
	// clock
	// ------------------------------------------------------------------
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// ------------------------------------------------------------------
	// byte driver: one word per item, random gap drawn per item
	// ------------------------------------------------------------------
	int  send_gap;
	bit  send_calm;

	always @(posedge clk) begin
		if (arst_n) begin
			if (in_ch.valid && in_ch.ready) begin
				escape_byte(in_ch.in_byte, in_ch.string_start, in_ch.string_end);
				bytes_sent++;
				if (in_ch.string_start)
					strings_sent++;
			end
			if (!in_ch.valid || in_ch.ready) begin
				if (send_gap != 0) begin
					send_gap--;
					in_ch.valid <= 1'b0;
				end else if (pending_bytes.size() != 0 &&
					!(pending_bytes[0].drain && expected_chars.size() != 0)) begin
					in_ch.valid        <= 1'b1;
					in_ch.in_byte      <= pending_bytes[0].data;
					in_ch.string_start <= pending_bytes[0].opens;
					in_ch.string_end   <= pending_bytes[0].closes;
					void'(pending_bytes.pop_front());
					if ($urandom_range(0, 39) == 0)
						send_calm = !send_calm;
					send_gap = send_calm ? 0 : $urandom_range(0, 7);
				end else begin
					in_ch.valid <= 1'b0;
				end
			end
		end
	end

	// ------------------------------------------------------------------
	// character monitor: checks each word, draws a stall per word
	// ------------------------------------------------------------------
	int  recv_stall;
	int  hold_left;
	bit  recv_calm;

	always @(posedge clk) begin
		char_word_t want;
		if (arst_n) begin
			if (out_ch.valid && out_ch.ready) begin
				chars_seen++;
				if (expected_chars.size() == 0) begin
					report_mismatch($sformatf("unexpected character %h", out_ch.out_char));
				end else begin
					want = expected_chars.pop_front();
					if (out_ch.out_char !== want.ch)
						report_mismatch($sformatf("char %0d: got %h, expected %h",
							chars_seen, out_ch.out_char, want.ch));
					if (out_ch.out_last !== want.last)
						report_mismatch($sformatf("char %0d: last got %b, expected %b",
							chars_seen, out_ch.out_last, want.last));
				end
				if ($urandom_range(0, 39) == 0)
					recv_calm = !recv_calm;
				recv_stall = recv_calm ? 0 : $urandom_range(0, 7);
				// one long hold so the block backs up into its input
				if (chars_seen == HOLD_AT)
					hold_left = HOLD_LEN;
			end
			if (hold_left != 0) begin
				hold_left--;
				out_ch.ready <= 1'b0;
			end else if (recv_stall != 0) begin
				recv_stall--;
				out_ch.ready <= 1'b0;
			end else begin
				out_ch.ready <= 1'b1;
			end
		end
	end

	// ------------------------------------------------------------------
	// watchdog: cycles with no word accepted on either side
	// ------------------------------------------------------------------
	int idle_cycles;

	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles == IDLE_LIMIT) begin
				$display("[%0t] watchdog: no word moved for %0d cycles", $time, IDLE_LIMIT);
				$display("tb: failure");
				$finish;
			end
		end
	end

	// ------------------------------------------------------------------
	// stimulus, reset and end of run
	// ------------------------------------------------------------------
	initial begin
		logic [7:0] str_bytes[$];
		logic [7:0] unit[4];
		int         n_cp;
		int         sel;
		int         nb;
		int         keep;
		int         queued_random;
		bit         with_open;
		bit         with_close;
		bit         drain_next;
		bit         mid_drained;

		arst_n = 1'b0;
		in_ch.valid = 1'b0;
		in_ch.in_byte = 8'h00;
		in_ch.string_start = 1'b0;
		in_ch.string_end = 1'b0;
		out_ch.ready = 1'b0;
		errors = 0;
		bytes_sent = 0;
		strings_sent = 0;
		chars_seen = 0;
		pairs_seen = 0;
		dec_pending = 2'd0;
		dec_code = '0;
		send_gap = 0;
		send_calm = 1'b0;
		recv_stall = 0;
		hold_left = 0;
		recv_calm = 0;
		idle_cycles = 0;

		// directed: escapes, controls, each sequence length, broken input
		queue_byte(8'h41, 1, 0, 0);
		queue_byte(8'h22, 0, 0, 0);
		queue_byte(8'h5C, 0, 0, 0);
		queue_byte(8'h20, 0, 0, 0);
		queue_byte(8'h7E, 0, 0, 0);
		queue_byte(8'h7F, 0, 0, 0);
		queue_byte(8'h00, 0, 0, 0);
		queue_byte(8'h1F, 0, 0, 0);
		queue_byte(8'hC3, 0, 0, 0);
		queue_byte(8'hA9, 0, 0, 0);
		queue_byte(8'hE2, 0, 0, 0);
		queue_byte(8'h82, 0, 0, 0);
		queue_byte(8'hAC, 0, 0, 0);
		queue_byte(8'hF0, 0, 0, 0);
		queue_byte(8'h9F, 0, 0, 0);
		queue_byte(8'h98, 0, 0, 0);
		queue_byte(8'h80, 0, 0, 0);
		// stray continuation, invalid lead, interrupted sequence
		queue_byte(8'h80, 0, 0, 0);
		queue_byte(8'hFF, 0, 0, 0);
		queue_byte(8'hE2, 0, 0, 0);
		queue_byte(8'h41, 0, 0, 0);
		// largest 4-byte value closing the string: pair plus quote
		queue_byte(8'hF7, 0, 0, 0);
		queue_byte(8'hBF, 0, 0, 0);
		queue_byte(8'hBF, 0, 0, 0);
		queue_byte(8'hBF, 0, 1, 0);
		// byte outside any string, then a lead cut off by the end marker
		queue_byte(8'h61, 0, 0, 0);
		queue_byte(8'hC3, 1, 1, 0);

		// random strings: mostly well formed, some noise and broken sequences
		queued_random = 0;
		drain_next = 1'b1;
		mid_drained = 1'b0;
		while (queued_random < RANDOM_BYTES) begin
			str_bytes.delete();
			n_cp = $urandom_range(1, 8);
			for (int c = 0; c < n_cp; c++) begin
				sel = $urandom_range(0, 9);
				if ($urandom_range(0, 9) == 0) begin
					unit[0] = 8'($urandom_range(0, 255));
					nb = 1;
				end else if (sel <= 3) begin
					unit[0] = 8'($urandom_range(0, 127));
					nb = 1;
				end else if (sel == 4) begin
					unit[0] = $urandom_range(0, 1) ? {1'b0, CH_QUOTE} : {1'b0, CH_BSL};
					nb = 1;
				end else if (sel <= 6) begin
					unit[0] = 8'hC0 | 8'($urandom_range(0, 31));
					nb = 2;
				end else if (sel == 7) begin
					unit[0] = 8'hE0 | 8'($urandom_range(0, 15));
					nb = 3;
				end else begin
					unit[0] = 8'hF0 | 8'($urandom_range(0, 7));
					nb = 4;
				end
				for (int k = 1; k < nb; k++)
					unit[k] = 8'h80 | 8'($urandom_range(0, 63));
				keep = nb;
				if (nb > 1 && $urandom_range(0, 15) == 0)
					keep = $urandom_range(1, nb - 1);
				for (int k = 0; k < keep; k++)
					str_bytes = {str_bytes, unit[k]};
			end
			with_open = ($urandom_range(0, 19) != 0);
			with_close = ($urandom_range(0, 19) != 0);
			if (!mid_drained && queued_random >= RANDOM_BYTES / 2) begin
				drain_next = 1'b1;
				mid_drained = 1'b1;
			end
			for (int k = 0; k < str_bytes.size(); k++) begin
				queue_byte(str_bytes[k], with_open && k == 0,
					with_close && k == str_bytes.size() - 1, drain_next);
				drain_next = 1'b0;
			end
			queued_random += str_bytes.size();
		end

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;

		while (pending_bytes.size() != 0 || in_ch.valid || expected_chars.size() != 0)
			@(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);

		if (expected_chars.size() != 0)
			report_mismatch($sformatf("%0d characters never came", expected_chars.size()));

		$display("run covered %0d bytes in %0d opened strings, %0d surrogate pairs",
			bytes_sent, strings_sent, pairs_seen);
		$display("%0d characters checked, %0d mismatches", chars_seen, errors);
		if (errors == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule

@@ utf8_to_json_string_escaper_unit.f @@
+incdir+sv
sv/u2j_pkg.sv
sv/u2j_in_if.sv
sv/u2j_out_if.sv
sv/u2j_front.sv
sv/u2j_queue.sv
sv/u2j_back.sv
sv/utf8_to_json_string_escaper_unit.sv
bench/utf8_to_json_string_escaper_unit_test.sv
